FILE: hw/rtl/llba_pkg.sv
// shared constants, types and state codes of the least-loaded bin assigner
`timescale 1ns / 1ps
`default_nettype none

package llba_pkg;

    // fixed field widths
    localparam int CFG_W      = 7;
    localparam int WEIGHT_W   = 16;
    localparam int BIN_NUM_W  = 7;
    localparam int LOAD_OUT_W = 32;

    // register reset value
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // parameter defaults
    localparam int DEF_MAX_BINS  = 64;
    localparam int DEF_LOAD_BITS = 32;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WRITE
    } t_state;

    // per-cell control strobes
    typedef struct packed {
        logic clear;
        logic wr;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: hw/rtl/llba_in_if.sv
// input item channel: valid/ready with weight and new-set flag
`timescale 1ns / 1ps
`default_nettype none

interface llba_in_if;
    logic                          valid;
    logic                          ready;
    logic [llba_pkg::WEIGHT_W-1:0] item_weight;
    logic                          start_new_set;

    modport source (output valid, output item_weight, output start_new_set, input ready);
    modport sink   (input valid, input item_weight, input start_new_set, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/llba_out_if.sv
// result channel: valid/ready with bin number, new load and saturation flag
`timescale 1ns / 1ps
`default_nettype none

interface llba_out_if;
    logic                            valid;
    logic                            ready;
    logic [llba_pkg::BIN_NUM_W-1:0]  bin_number;
    logic [llba_pkg::LOAD_OUT_W-1:0] new_bin_load;
    logic                            load_saturated;

    modport source (output valid, output bin_number, output new_bin_load,
                    output load_saturated, input ready);
    modport sink   (input valid, input bin_number, input new_bin_load,
                    input load_saturated, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/llba_cell.sv
// one bin cell: holds a load and forwards the running minimum token
`timescale 1ns / 1ps
`default_nettype none

module llba_cell #(
    parameter int LOAD_BITS = llba_pkg::DEF_LOAD_BITS,
    parameter int IDX_W     = 6,
    parameter int IDX       = 0
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  llba_pkg::t_cell_ctl          i_ctl,
    input  wire  [LOAD_BITS-1:0]         i_wr_load,
    input  wire  [llba_pkg::CFG_W-1:0]   i_bins_in_use,
    input  wire                          i_tok_vld,
    input  wire  [LOAD_BITS-1:0]         i_tok_load,
    input  wire  [IDX_W-1:0]             i_tok_idx,
    output logic                         o_tok_vld,
    output logic [LOAD_BITS-1:0]         o_tok_load,
    output logic [IDX_W-1:0]             o_tok_idx
);

    localparam int CMP_W = ((IDX_W > llba_pkg::CFG_W) ? IDX_W : llba_pkg::CFG_W) + 1;

    logic [LOAD_BITS-1:0] r_load;
    logic                 r_tok_vld;
    logic [LOAD_BITS-1:0] r_tok_load;
    logic [IDX_W-1:0]     r_tok_idx;
    logic                 active;
    logic                 take_mine;

    // bin zero always takes part, others only below the configured count
    assign active    = (IDX == 0) || (CMP_W'(i_bins_in_use) > CMP_W'(IDX));
    assign take_mine = active && (r_load < i_tok_load);

    // bin load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= '0;
        end else if (i_ctl.clear) begin
            r_load <= '0;
        end else if (i_ctl.wr) begin
            r_load <= i_wr_load;
        end
    end

    // token valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok_vld;
        end
    end

    // token payload, strict compare keeps the lower bin on a tie
    always_ff @(posedge i_clk) begin
        if (i_tok_vld) begin
            if (take_mine) begin
                r_tok_load <= r_load;
                r_tok_idx  <= IDX_W'(IDX);
            end else begin
                r_tok_load <= i_tok_load;
                r_tok_idx  <= i_tok_idx;
            end
        end
    end

    assign o_tok_vld  = r_tok_vld;
    assign o_tok_load = r_tok_load;
    assign o_tok_idx  = r_tok_idx;

endmodule

`default_nettype wire

FILE: hw/rtl/least_loaded_bin_assigner_core.sv
// top level: bin cell chain, search control, load update and result register
//
//  channel    dir  handshake      payload
//  i_item     in   valid/ready    item_weight[15:0], start_new_set
//  o_result   out  valid/ready    bin_number[6:0], new_bin_load[31:0], load_saturated
//  i_cfg_*    in   write enable   i_cfg_wdata[6:0] -> bins_in_use
//
// an item goes through these steps in order: accept (and clear on a new set),
// launch the token, walk it along the cell chain, and write back.
// one item is in the chain at a time; the next is accepted as soon as the
// write-back is done, even while the previous result still waits downstream.
// a stalled result holds the write-back until the output register frees up.
// reset is synchronous and clears all bin loads at once; bins_in_use goes to 64.
`timescale 1ns / 1ps
`default_nettype none

module least_loaded_bin_assigner_core #(
    parameter int MAX_BINS  = llba_pkg::DEF_MAX_BINS,
    parameter int LOAD_BITS = llba_pkg::DEF_LOAD_BITS
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    llba_in_if.sink                    i_item,
    llba_out_if.source                 o_result,
    input  wire                        i_cfg_we,
    input  wire [llba_pkg::CFG_W-1:0]  i_cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int CMP_W = ((IDX_W > llba_pkg::CFG_W) ? IDX_W : llba_pkg::CFG_W) + 1;
    localparam int PAD_W = 64;

    llba_pkg::t_state                  r_state;
    llba_pkg::t_state                  n_state;
    logic [llba_pkg::CFG_W-1:0]        r_bins_in_use;
    logic [llba_pkg::WEIGHT_W-1:0]     r_weight;
    logic                              r_inject;

    logic                              r_out_vld;
    logic [llba_pkg::BIN_NUM_W-1:0]    r_bin_number;
    logic [llba_pkg::LOAD_OUT_W-1:0]   r_new_bin_load;
    logic                              r_load_saturated;

    logic [MAX_BINS:0]                 tok_vld;
    logic [LOAD_BITS-1:0]              tok_load [MAX_BINS+1];
    logic [IDX_W-1:0]                  tok_idx  [MAX_BINS+1];
    llba_pkg::t_cell_ctl               cell_ctl [MAX_BINS];

    logic                              in_xfer;
    logic                              out_free;
    logic                              do_write;
    logic [LOAD_BITS:0]                sum_ext;
    logic                              sat;
    logic [LOAD_BITS-1:0]              sum_sat;
    logic [IDX_W:0]                    bin_num_ext;
    logic [PAD_W-1:0]                  sum_pad;
    logic [PAD_W-1:0]                  num_pad;

    // handshake
    assign i_item.ready = (r_state == llba_pkg::ST_IDLE);
    assign in_xfer      = i_item.valid && i_item.ready;
    assign out_free     = !r_out_vld || o_result.ready;
    assign do_write     = (r_state == llba_pkg::ST_WRITE) && out_free;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins_in_use <= llba_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_bins_in_use <= i_cfg_wdata;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= llba_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            llba_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = llba_pkg::ST_SEARCH;
                end
            end
            llba_pkg::ST_SEARCH: begin
                if (tok_vld[MAX_BINS]) begin
                    n_state = llba_pkg::ST_WRITE;
                end
            end
            llba_pkg::ST_WRITE: begin
                if (out_free) begin
                    n_state = llba_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = llba_pkg::ST_IDLE;
            end
        endcase
    end

    // token launch in the cycle after the transfer, after any clear has landed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inject <= 1'b0;
        end else begin
            r_inject <= in_xfer;
        end
    end

    // item weight
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_weight <= i_item.item_weight;
        end
    end

    // chain head: a max-load token that bin zero always beats or ties
    assign tok_vld[0]  = r_inject;
    assign tok_load[0] = '1;
    assign tok_idx[0]  = '0;

    // cell chain
    for (genvar g = 0; g < MAX_BINS; g++) begin : g_cell
        assign cell_ctl[g].clear = in_xfer && i_item.start_new_set;
        assign cell_ctl[g].wr    = do_write && (tok_idx[MAX_BINS] == IDX_W'(g));

        llba_cell #(
            .LOAD_BITS (LOAD_BITS),
            .IDX_W     (IDX_W),
            .IDX       (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (cell_ctl[g]),
            .i_wr_load     (sum_sat),
            .i_bins_in_use (r_bins_in_use),
            .i_tok_vld     (tok_vld[g]),
            .i_tok_load    (tok_load[g]),
            .i_tok_idx     (tok_idx[g]),
            .o_tok_vld     (tok_vld[g+1]),
            .o_tok_load    (tok_load[g+1]),
            .o_tok_idx     (tok_idx[g+1])
        );
    end

    // saturating add on the winning load, held at the chain tail
    assign sum_ext     = {1'b0, tok_load[MAX_BINS]} + (LOAD_BITS+1)'(r_weight);
    assign sat         = sum_ext[LOAD_BITS];
    assign sum_sat     = sat ? '1 : sum_ext[LOAD_BITS-1:0];
    assign bin_num_ext = {1'b0, tok_idx[MAX_BINS]} + (IDX_W+1)'(1);
    assign sum_pad     = PAD_W'(sum_sat);
    assign num_pad     = PAD_W'(bin_num_ext);

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (do_write) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_bin_number     <= num_pad[llba_pkg::BIN_NUM_W-1:0];
            r_new_bin_load   <= sum_pad[llba_pkg::LOAD_OUT_W-1:0];
            r_load_saturated <= sat;
        end
    end

    assign o_result.valid          = r_out_vld;
    assign o_result.bin_number     = r_bin_number;
    assign o_result.new_bin_load   = r_new_bin_load;
    assign o_result.load_saturated = r_load_saturated;

    // at most one token walks the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(tok_vld) <= 1)
        else $error("more than one token in the cell chain");

    // the token only leaves the chain during a search
    a_tail_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_vld[MAX_BINS] |-> (r_state == llba_pkg::ST_SEARCH))
        else $error("token reached chain tail outside a search");

    // the chosen bin is one that takes part
    a_pick_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == llba_pkg::ST_WRITE) |->
            ((tok_idx[MAX_BINS] == '0) ||
             (CMP_W'(tok_idx[MAX_BINS]) < CMP_W'(r_bins_in_use))))
        else $error("chosen bin lies beyond the bins in use");

    // a write-back always produces a result on the next cycle
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_write |=> r_out_vld)
        else $error("write-back did not raise the result");

endmodule

`default_nettype wire

FILE: tb/sv/least_loaded_bin_assigner_core_tb.sv
// testbench for the least-loaded bin assigner core: directed and random placement checks
`timescale 1ns / 1ps

module least_loaded_bin_assigner_core_tb;
    import llba_pkg::*;

    localparam int                   NUM_BINS      = DEF_MAX_BINS;
    localparam logic [LOAD_OUT_W-1:0] LOAD_MAX     = '1;
    localparam int                   HOLD_CYCLES   = 400;
    localparam int                   WATCHDOG_MAX  = 3000;
    localparam int                   SETTLE_CYCLES = 100;

    // one expected placement
    typedef struct packed {
        logic [BIN_NUM_W-1:0]  bin;
        logic [LOAD_OUT_W-1:0] load;
        logic                  sat;
    } t_placement;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    llba_in_if  item_if ();
    llba_out_if result_if ();

    least_loaded_bin_assigner_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_result    (result_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // predictor state
    logic [LOAD_OUT_W-1:0] bin_load_model [NUM_BINS];
    logic [CFG_W-1:0]      bins_cfg;
    t_placement            placement_q [$];

    // run control and statistics
    bit idle_en;
    bit hold_req;
    int items_sent;
    int results_checked;
    int saturated_seen;
    int cfg_writes;
    int mismatches;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // number of bins taking part, with the out-of-range settings folded in
    function automatic int active_bin_count();
        int n;
        n = bins_cfg;
        if (n == 0) n = 1;
        if (n > NUM_BINS) n = NUM_BINS;
        return n;
    endfunction

    // place one item on the model and return the placement it causes
    function automatic t_placement predict_placement(logic [WEIGHT_W-1:0] weight,
                                                     logic new_set);
        t_placement p;
        int pick;
        int i;
        logic [LOAD_OUT_W:0] sum;
        if (new_set) begin
            for (i = 0; i < NUM_BINS; i++) bin_load_model[i] = '0;
        end
        pick = 0;
        for (i = 1; i < active_bin_count(); i++) begin
            if (bin_load_model[i] < bin_load_model[pick]) pick = i;
        end
        sum = {1'b0, bin_load_model[pick]} + weight;
        p.sat = sum[LOAD_OUT_W];
        bin_load_model[pick] = p.sat ? LOAD_MAX : sum[LOAD_OUT_W-1:0];
        p.bin  = BIN_NUM_W'(pick + 1);
        p.load = bin_load_model[pick];
        return p;
    endfunction

    // offer one item, optionally after an idle burst, and record its placement on transfer
    task automatic offer_item(logic [WEIGHT_W-1:0] weight, logic new_set);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        item_if.valid         <= 1'b1;
        item_if.item_weight   <= weight;
        item_if.start_new_set <= new_set;
        do @(posedge i_clk); while (!item_if.ready);
        placement_q.insert(placement_q.size(), predict_placement(weight, new_set));
        items_sent++;
    endtask

    // stop offering and wait until every placement has been reported
    task automatic drain_results();
        item_if.valid <= 1'b0;
        while (placement_q.size() != 0) @(posedge i_clk);
    endtask

    // write bins_in_use while the block is idle
    task automatic write_bins(logic [CFG_W-1:0] value);
        drain_results();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        bins_cfg = value;
        cfg_writes++;
        @(posedge i_clk);
    endtask

    // random weight, biased toward the extremes and toward small values that tie
    function automatic logic [WEIGHT_W-1:0] pick_weight();
        int mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0:       return '0;
            1:       return '1;
            2, 3:    return WEIGHT_W'($urandom_range(0, 15));
            default: return WEIGHT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // result side: check each transfer, then decide ready for the next cycle
    initial begin
        int stall_left;
        int hold_left;
        t_placement exp_p;
        stall_left = 0;
        hold_left  = 0;
        result_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_if.valid && result_if.ready) begin
                if (placement_q.size() == 0) begin
                    $error("result with no placement expected: bin %0d load %0d",
                           result_if.bin_number, result_if.new_bin_load);
                    mismatches++;
                end else begin
                    exp_p = placement_q.pop_front();
                    results_checked++;
                    if (result_if.load_saturated) saturated_seen++;
                    if (result_if.bin_number !== exp_p.bin) begin
                        $error("bin_number: expected %0d, actual %0d",
                               exp_p.bin, result_if.bin_number);
                        mismatches++;
                    end
                    if (result_if.new_bin_load !== exp_p.load) begin
                        $error("new_bin_load: expected %0d, actual %0d",
                               exp_p.load, result_if.new_bin_load);
                        mismatches++;
                    end
                    if (result_if.load_saturated !== exp_p.sat) begin
                        $error("load_saturated: expected %0d, actual %0d",
                               exp_p.sat, result_if.load_saturated);
                        mismatches++;
                    end
                end
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                result_if.ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // watchdog: too long without any transfer ends the run
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("timeout: no transfer for %0d cycles", quiet_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // reset value of bins_in_use, ties and the weight extremes
    task automatic test_reset_defaults();
        offer_item(16'hFFFF, 1'b1);
        offer_item(16'h0000, 1'b0);
        offer_item(16'h0000, 1'b0);
        offer_item(16'h0001, 1'b0);
        offer_item(16'hFFFF, 1'b0);
        drain_results();
    endtask

    // zero bins and more bins than exist
    task automatic test_bin_count_limits();
        write_bins(7'd0);
        offer_item(16'd7, 1'b1);
        offer_item(16'd9, 1'b0);
        offer_item(16'd0, 1'b0);
        write_bins(7'd127);
        offer_item(16'd1, 1'b1);
        offer_item(16'd1, 1'b0);
        drain_results();
    endtask

    // bins outside the active range keep their loads and return when the range grows
    task automatic test_bins_left_out();
        write_bins(7'd4);
        offer_item(16'd10, 1'b1);
        offer_item(16'd20, 1'b0);
        offer_item(16'd30, 1'b0);
        offer_item(16'd40, 1'b0);
        write_bins(7'd2);
        offer_item(16'd5, 1'b0);
        offer_item(16'd5, 1'b0);
        write_bins(7'd64);
        offer_item(16'd0, 1'b0);
        offer_item(16'd3, 1'b0);
        drain_results();
    endtask

    // long receiver hold-off while items keep coming, then a full drain pause
    task automatic test_backpressure();
        write_bins(7'd8);
        hold_req = 1'b1;
        repeat (12) offer_item(pick_weight(), 1'b0);
        drain_results();
        repeat (6) offer_item(pick_weight(), $urandom_range(0, 7) == 0);
        drain_results();
    endtask

    // random phases across several bin counts, some without idling
    task automatic test_random_mix();
        logic [CFG_W-1:0] phase_cfg [7];
        int p;
        phase_cfg[0] = 7'd1;
        phase_cfg[1] = 7'd64;
        phase_cfg[2] = 7'd2;
        phase_cfg[3] = CFG_W'($urandom_range(3, 63));
        phase_cfg[4] = CFG_W'($urandom_range(0, 127));
        phase_cfg[5] = 7'd127;
        phase_cfg[6] = CFG_W'($urandom_range(3, 16));
        for (p = 0; p < 7; p++) begin
            write_bins(phase_cfg[p]);
            idle_en = (p != 2 && p != 5);
            repeat (265) offer_item(pick_weight(), $urandom_range(0, 24) == 0);
        end
        idle_en = 1'b1;
        drain_results();
    endtask

    // one bin driven to a large load with full weights, zero weight, then a second bin joins
    task automatic test_heavy_load();
        idle_en = 1'b0;
        write_bins(7'd1);
        offer_item(16'hFFFF, 1'b1);
        repeat (63) offer_item(16'hFFFF, 1'b0);
        offer_item(16'd0, 1'b0);
        offer_item(16'd1, 1'b0);
        write_bins(7'd2);
        offer_item(16'd3, 1'b0);
        offer_item(16'hFFFF, 1'b0);
        drain_results();
    endtask

    // main sequence
    initial begin
        int i;
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_wdata           = '0;
        item_if.valid         = 1'b0;
        item_if.item_weight   = '0;
        item_if.start_new_set = 1'b0;
        for (i = 0; i < NUM_BINS; i++) bin_load_model[i] = '0;
        bins_cfg        = CFG_RESET;
        idle_en         = 1'b1;
        hold_req        = 1'b0;
        items_sent      = 0;
        results_checked = 0;
        saturated_seen  = 0;
        cfg_writes      = 0;
        mismatches      = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_bin_count_limits();
        test_bins_left_out();
        test_backpressure();
        test_random_mix();
        test_heavy_load();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d items over %0d bin-count writes (0, 1, 2, 64, 127 and random)",
                 items_sent, cfg_writes);
        $display("%0d placements checked, %0d of them saturated", results_checked,
                 saturated_seen);
        if (mismatches == 0 && placement_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
